// ----- rtl/dftp_pkg.sv -----
// Shared types, constants and trig-table builder for the single-bin DFT power meter.
package dftp_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int PHASE_W   = 32;
    localparam int DISCARD_W = 24;
    localparam int MEASURE_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W     = 34;
    localparam int SUM_W     = 33;
    localparam int MAG_W     = 32;
    localparam int POWER_W   = 63;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 66;

    localparam logic signed [ACC_W-1:0] ACC_LIMIT = 34'sd4294967295;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_COUNT = 2'd2;

    localparam logic [PHASE_W-1:0]   PHASE_STEP_RST    = 32'd1605561855;
    localparam logic [DISCARD_W-1:0] DISCARD_COUNT_RST = 24'd1000000;
    localparam logic [MEASURE_W-1:0] MEASURE_COUNT_RST = 16'd5000;

    // pi/2 in Q30 and the Taylor divisors (2n)(2n+1) for n = 1..10
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SERIES_DIV [10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    // Quarter-wave sine entry k, evaluated at elaboration only.
    function automatic int dftp_quarter_entry(int k, int addr_bits, int coef_bits);
        longint unsigned x;
        longint unsigned t;
        longint unsigned amp;
        longint unsigned prod;
        longint          s;
        int              n;
        x = (longint'(k) * HALF_PI_Q30) >> (addr_bits - 2);
        t = x;
        s = longint'(x);
        for (n = 0; n < 10; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / SERIES_DIV[n];
            if (n[0] == 1'b0) begin
                s = s - longint'(t);
            end else begin
                s = s + longint'(t);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        if (s > (longint'(1) << 30)) begin
            s = longint'(1) << 30;
        end
        amp  = (64'd1 << (coef_bits - 1)) - 64'd1;
        prod = (64'(s) * amp + (64'd1 << 29)) >> 30;
        return int'(prod);
    endfunction

endpackage

// ----- rtl/dftp_trig_rom.sv -----
// Sine table ROM: quarter-wave constants, quadrant folding, registered read.
module dftp_trig_rom
    import dftp_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int COEF_BITS       = 10
) (
    input  logic                        aclk,
    input  logic [TABLE_ADDR_BITS-1:0]  addr,
    output logic signed [COEF_BITS-1:0] coef_reg
);

    localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
    localparam int IDX_W   = TABLE_ADDR_BITS - 1;

    logic [COEF_BITS-1:0] qtab [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_qtab
        localparam int QV = dftp_quarter_entry(k, TABLE_ADDR_BITS, COEF_BITS);
        assign qtab[k] = QV[COEF_BITS-1:0];
    end

    logic [1:0]                   quad;
    logic [TABLE_ADDR_BITS-3:0]   rem;
    logic [IDX_W-1:0]             idx;
    logic signed [COEF_BITS-1:0]  mag;
    logic signed [COEF_BITS-1:0]  coef_next;

    always_comb begin
        quad = addr[TABLE_ADDR_BITS-1 -: 2];
        rem  = addr[TABLE_ADDR_BITS-3:0];
        // odd quadrants read the table backwards
        if (quad[0]) begin
            idx = IDX_W'(QUARTER) - {1'b0, rem};
        end else begin
            idx = {1'b0, rem};
        end
        mag       = $signed(qtab[idx]);
        coef_next = quad[1] ? -mag : mag;
    end

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
    end

endmodule

// ----- rtl/dftp_mul.sv -----
// Shared signed multiplier with registered product.
module dftp_mul
    import dftp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ----- rtl/single_bin_dft_power.sv -----
// Single-bin DFT power meter: sequencer, accumulators, config registers, output register.
//
//  channel   | ports                                  | dir | notes
//  ----------+----------------------------------------+-----+-------------------------------
//  sample    | s_valid s_ready s_sample[7:0]          | in  | signed baseband request
//  result    | m_valid m_ready m_power m_real/imag_sum| out | one request per window
//  config    | cfg_we cfg_index[1:0] cfg_wdata[31:0]  | in  | write only, no wait
//
// Sequence: a discarded sample is taken in the idle state; a measured sample goes through
//   accept, cos multiply, sin multiply and accumulate on the single shared multiplier.
// The last sample of a window goes on through two squares on the same multiplier and the sum.
// Reset: aresetn synchronous, active low; config returns to defaults, counters clear.
// Stalls: a finished result waits in the output register; new samples are still taken,
//   and the block only holds at the end of the next window if that result is still pending.
module single_bin_dft_power
    import dftp_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int COEF_BITS       = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SAMPLE_W-1:0]  s_sample,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [POWER_W-1:0]          m_power,
    output logic signed [SUM_W-1:0]     m_real_sum,
    output logic signed [SUM_W-1:0]     m_imag_sum,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_COS,
        ST_MUL_SIN,
        ST_ACC_SIN,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_DONE
    } state_t;

    state_t state_reg;

    // config registers
    logic [PHASE_W-1:0]   phase_step_reg;
    logic [DISCARD_W-1:0] discard_count_reg;
    logic [MEASURE_W-1:0] measure_count_reg;

    // datapath state
    logic                     measuring_reg;
    logic [DISCARD_W-1:0]     counter_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic signed [ACC_W-1:0]  real_acc_reg;
    logic signed [ACC_W-1:0]  imag_acc_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [2*MAG_W-1:0]       sq_re_reg;

    // output register
    logic                     m_valid_reg;
    logic [POWER_W-1:0]       m_power_reg;
    logic signed [SUM_W-1:0]  m_real_reg;
    logic signed [SUM_W-1:0]  m_imag_reg;

    // shared units
    logic signed [COEF_BITS-1:0] coef_reg;
    logic [TABLE_ADDR_BITS-1:0]  rom_addr;
    logic                        mul_en;
    logic signed [MUL_W-1:0]     mul_a;
    logic signed [MUL_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]    prod_reg;

    dftp_trig_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .COEF_BITS       (COEF_BITS)
    ) u_rom (
        .aclk     (aclk),
        .addr     (rom_addr),
        .coef_reg (coef_reg)
    );

    dftp_mul u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    logic                     accept;
    logic                     discard_hit;
    logic                     out_free;
    logic [PHASE_W-1:0]       phase_eff;
    logic [TABLE_ADDR_BITS-1:0] phase_addr;
    logic [TABLE_ADDR_BITS-1:0] base_addr;
    logic signed [ACC_W-1:0]  real_sum;
    logic signed [ACC_W-1:0]  imag_sum;
    logic signed [ACC_W-1:0]  real_sat;
    logic signed [ACC_W-1:0]  imag_sat;
    logic [ACC_W-1:0]         real_neg;
    logic [ACC_W-1:0]         imag_neg;
    logic [MAG_W-1:0]         mag_re;
    logic [MAG_W-1:0]         mag_im;
    logic [2*MAG_W:0]         power_sum;
    logic [DISCARD_W-1:0]     counter_inc;
    logic                     window_end;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign discard_hit = !measuring_reg && (counter_reg < discard_count_reg);
    assign out_free    = !m_valid_reg || m_ready;
    assign counter_inc = counter_reg + DISCARD_W'(1);
    assign window_end  = (counter_inc >= {{(DISCARD_W-MEASURE_W){1'b0}}, measure_count_reg});

    // a new window starts its phase at zero
    assign phase_eff  = measuring_reg ? phase_reg : '0;
    assign phase_addr = (state_reg == ST_IDLE) ? phase_eff[PHASE_W-1 -: TABLE_ADDR_BITS]
                                               : phase_reg[PHASE_W-1 -: TABLE_ADDR_BITS];

    always_comb begin
        base_addr = phase_addr;
        // cos in the accept cycle, sin while the cos product is formed
        if (state_reg == ST_IDLE) begin
            rom_addr = base_addr + TABLE_ADDR_BITS'(QUARTER);
        end else begin
            rom_addr = base_addr;
        end
    end

    // magnitudes of the saturated sums fit in 32 bits
    always_comb begin
        real_neg = -real_acc_reg;
        imag_neg = -imag_acc_reg;
        mag_re   = real_acc_reg[ACC_W-1] ? real_neg[MAG_W-1:0] : real_acc_reg[MAG_W-1:0];
        mag_im   = imag_acc_reg[ACC_W-1] ? imag_neg[MAG_W-1:0] : imag_acc_reg[MAG_W-1:0];
    end

    // multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = MUL_W'(sample_reg);
        mul_b  = MUL_W'(coef_reg);
        unique case (state_reg)
            ST_MUL_COS, ST_MUL_SIN: begin
                mul_en = 1'b1;
            end
            ST_SQ_RE: begin
                mul_en = 1'b1;
                mul_a  = $signed({1'b0, mag_re});
                mul_b  = $signed({1'b0, mag_re});
            end
            ST_SQ_IM: begin
                mul_en = 1'b1;
                mul_a  = $signed({1'b0, mag_im});
                mul_b  = $signed({1'b0, mag_im});
            end
            ST_IDLE, ST_ACC_SIN, ST_DONE: begin
                mul_en = 1'b0;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // saturating accumulate; sums cannot leave 34 bits
    always_comb begin
        real_sum = real_acc_reg + prod_reg[ACC_W-1:0];
        imag_sum = imag_acc_reg + prod_reg[ACC_W-1:0];
        priority if (real_sum > ACC_LIMIT) begin
            real_sat = ACC_LIMIT;
        end else if (real_sum < -ACC_LIMIT) begin
            real_sat = -ACC_LIMIT;
        end else begin
            real_sat = real_sum;
        end
        priority if (imag_sum > ACC_LIMIT) begin
            imag_sat = ACC_LIMIT;
        end else if (imag_sum < -ACC_LIMIT) begin
            imag_sat = -ACC_LIMIT;
        end else begin
            imag_sat = imag_sum;
        end
    end

    assign power_sum = {1'b0, sq_re_reg} + {1'b0, prod_reg[2*MAG_W-1:0]};

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg    <= PHASE_STEP_RST;
            discard_count_reg <= DISCARD_COUNT_RST;
            measure_count_reg <= MEASURE_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PHASE_STEP:    phase_step_reg    <= cfg_wdata;
                CFG_DISCARD_COUNT: discard_count_reg <= cfg_wdata[DISCARD_W-1:0];
                CFG_MEASURE_COUNT: measure_count_reg <= cfg_wdata[MEASURE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, accumulators and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            measuring_reg <= 1'b0;
            counter_reg   <= '0;
            phase_reg     <= '0;
            real_acc_reg  <= '0;
            imag_acc_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // the final state reloads the output register on its own
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (discard_hit) begin
                            counter_reg <= counter_inc;
                        end else begin
                            sample_reg <= s_sample;
                            state_reg  <= ST_MUL_COS;
                            if (!measuring_reg) begin
                                measuring_reg <= 1'b1;
                                counter_reg   <= '0;
                                phase_reg     <= '0;
                                real_acc_reg  <= '0;
                                imag_acc_reg  <= '0;
                            end
                        end
                    end
                end
                ST_MUL_COS: begin
                    state_reg <= ST_MUL_SIN;
                end
                ST_MUL_SIN: begin
                    real_acc_reg <= real_sat;
                    state_reg    <= ST_ACC_SIN;
                end
                ST_ACC_SIN: begin
                    imag_acc_reg <= imag_sat;
                    phase_reg    <= phase_reg + phase_step_reg;
                    if (window_end) begin
                        measuring_reg <= 1'b0;
                        counter_reg   <= '0;
                        state_reg     <= ST_SQ_RE;
                    end else begin
                        counter_reg <= counter_inc;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_SQ_RE: begin
                    state_reg <= ST_SQ_IM;
                end
                ST_SQ_IM: begin
                    sq_re_reg <= prod_reg[2*MAG_W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_power_reg <= power_sum[2*MAG_W:2];
                        m_real_reg  <= real_acc_reg[SUM_W-1:0];
                        m_imag_reg  <= imag_acc_reg[SUM_W-1:0];
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_power    = m_power_reg;
    assign m_real_sum = m_real_reg;
    assign m_imag_sum = m_imag_reg;

    // a result only appears out of the final state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside final state");

    // accumulators never leave the saturation range
    a_acc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (real_acc_reg <= ACC_LIMIT) && (real_acc_reg >= -ACC_LIMIT) &&
        (imag_acc_reg <= ACC_LIMIT) && (imag_acc_reg >= -ACC_LIMIT))
        else $error("accumulator out of range");

    // a measured sample starts the multiply sequence
    a_measure_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !discard_hit) |=> (state_reg == ST_MUL_COS) && measuring_reg)
        else $error("measured sample did not start sequence");

    // the window counter stays within the 16-bit window length
    a_window_count: assert property (@(posedge aclk) disable iff (!aresetn)
        measuring_reg |-> (counter_reg[DISCARD_W-1:MEASURE_W] == '0))
        else $error("window counter overran");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(m_power_reg))
        else $error("pending result lost");

endmodule

// ----- dv/tb_single_bin_dft_power.sv -----
// Self-checking testbench for the single-bin DFT power meter: directed table, random windows.
module tb_single_bin_dft_power;
    timeunit 1ns;
    timeprecision 1ps;

    import dftp_pkg::*;

    // DUT build and a private copy of the trig table geometry
    localparam int TAB_BITS  = 10;
    localparam int COEF_W    = 10;
    localparam int TAB_SIZE  = 1 << TAB_BITS;
    localparam int QUARTER   = TAB_SIZE / 4;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint SUM_CAP = 64'sd4294967295;

    // index 3 decodes to nothing; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // per-row register write mask
    localparam logic [3:0] WR_STEP  = 4'b0001;
    localparam logic [3:0] WR_DISC  = 4'b0010;
    localparam logic [3:0] WR_MEAS  = 4'b0100;
    localparam logic [3:0] WR_SPARE = 4'b1000;

    // idle cycles after the last result before touching registers or ending;
    // covers a measured sample plus the squaring tail with margin
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_SAMPLES = 1540;
    localparam int MIN_RANDOM_WINDOWS = 40;
    localparam int LONG_WINDOW = 128;

    typedef struct packed {
        logic [POWER_W-1:0]     power;
        logic signed [SUM_W-1:0] real_sum;
        logic signed [SUM_W-1:0] imag_sum;
    } window_t;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_CONST, FILL_SWING} fill_t;

    typedef struct {
        logic [3:0]              wr;
        logic [31:0]             step;
        logic [31:0]             discard;
        logic [31:0]             measure;
        int unsigned             count;
        fill_t                   fill;
        logic signed [SAMPLE_W-1:0] level;
        bit                      typed;
        window_t                 want;
    } plan_row_t;

    // ---------------------------------------------------------------- DUT I/O
    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [SAMPLE_W-1:0]   s_sample = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [POWER_W-1:0]           m_power;
    logic signed [SUM_W-1:0]      m_real_sum;
    logic signed [SUM_W-1:0]      m_imag_sum;
    logic                         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_wdata = '0;

    single_bin_dft_power #(
        .TABLE_ADDR_BITS(TAB_BITS),
        .COEF_BITS      (COEF_W)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_power   (m_power),
        .m_real_sum(m_real_sum),
        .m_imag_sum(m_imag_sum),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop, sized for every request taking the longest pause
    initial begin
        #150_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- correlator model
    int unsigned        quarter_sine [0:QUARTER];

    // shadow registers
    logic [31:0]        cur_step;
    logic [23:0]        cur_discard;
    logic [15:0]        cur_measure;

    // shadow datapath state
    bit                 in_window;
    logic [23:0]        win_count;
    logic [31:0]        win_phase;
    longint             acc_re;
    longint             acc_im;

    longint unsigned    items_total = 0;
    longint unsigned    windows_total = 0;

    window_t            pending_windows [$];
    int unsigned        errors = 0;

    // typed-in expectation overrides the model output for trivially known rows
    bit                 typed_on = 1'b0;
    window_t            typed_win;
    bit                 tx_steady = 1'b0;

    // quarter-wave sine by an 11-term Taylor series in Q30, then scaled to the coef width
    function automatic void build_quarter_sine();
        longint unsigned x;
        longint unsigned t;
        longint unsigned amp;
        longint          s;
        int              k;
        int              n;
        amp = (64'd1 << (COEF_W - 1)) - 64'd1;
        for (k = 0; k <= QUARTER; k++) begin
            x = (longint'(k) * PI_HALF_Q30) / QUARTER;
            t = x;
            s = longint'(x);
            for (n = 1; n <= 10; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / (longint'(2 * n) * longint'(2 * n + 1));
                if (n % 2 == 1) begin
                    s = s - longint'(t);
                end else begin
                    s = s + longint'(t);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            if (s > (longint'(1) << 30)) begin
                s = longint'(1) << 30;
            end
            quarter_sine[k] = int'((longint'(s) * amp + (64'd1 << 29)) >> 30);
        end
    endfunction

    function automatic longint sine_of(int unsigned i);
        int unsigned r;
        r = i % QUARTER;
        case ((i / QUARTER) % 4)
            0:       return longint'(quarter_sine[r]);
            1:       return longint'(quarter_sine[QUARTER - r]);
            2:       return -longint'(quarter_sine[r]);
            default: return -longint'(quarter_sine[QUARTER - r]);
        endcase
    endfunction

    function automatic longint clamp_sum(longint v);
        if (v > SUM_CAP) begin
            return SUM_CAP;
        end
        if (v < -SUM_CAP) begin
            return -SUM_CAP;
        end
        return v;
    endfunction

    // Advance the model by one accepted sample; returns 1 when a window closes.
    function automatic bit correlate_sample(input logic signed [SAMPLE_W-1:0] smp,
                                            output window_t res);
        int unsigned addr;
        logic [65:0] mag_re;
        logic [65:0] mag_im;
        logic [65:0] pw;
        res = '0;
        items_total++;
        if (!in_window) begin
            if (win_count < cur_discard) begin
                win_count = win_count + 24'd1;
                return 1'b0;
            end
            in_window = 1'b1;
            win_count = '0;
            win_phase = '0;
            acc_re    = 0;
            acc_im    = 0;
        end
        addr      = win_phase >> (32 - TAB_BITS);
        acc_re    = clamp_sum(acc_re + longint'(smp) * sine_of((addr + QUARTER) % TAB_SIZE));
        acc_im    = clamp_sum(acc_im + longint'(smp) * sine_of(addr));
        win_phase = win_phase + cur_step;
        win_count = win_count + 24'd1;
        // measure of zero closes after one sample, same as one
        if (win_count < {8'd0, cur_measure}) begin
            return 1'b0;
        end
        mag_re = (acc_re < 0) ? 66'(-acc_re) : 66'(acc_re);
        mag_im = (acc_im < 0) ? 66'(-acc_im) : 66'(acc_im);
        pw     = (mag_re * mag_re + mag_im * mag_im) >> 2;
        res.power    = pw[POWER_W-1:0];
        res.real_sum = acc_re[SUM_W-1:0];
        res.imag_sum = acc_im[SUM_W-1:0];
        in_window = 1'b0;
        win_count = '0;
        windows_total++;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- helpers
    // mostly back-to-back, some short pauses, a few long ones
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 8'sh7F;
            1:       return 8'sh80;
            2:       return ($urandom_range(0, 1) != 0) ? 8'sh00 : 8'shFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic plan_row_t mk_row(logic [3:0] wr, logic [31:0] step,
                                         logic [31:0] discard, logic [31:0] measure,
                                         int unsigned count, fill_t fill,
                                         logic signed [SAMPLE_W-1:0] level,
                                         bit typed, window_t want);
        plan_row_t row;
        row.wr      = wr;
        row.step    = step;
        row.discard = discard;
        row.measure = measure;
        row.count   = count;
        row.fill    = fill;
        row.level   = level;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    // register write; the shadow copy follows the same field masking
    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PHASE_STEP:    cur_step    = data;
            CFG_DISCARD_COUNT: cur_discard = data[DISCARD_W-1:0];
            CFG_MEASURE_COUNT: cur_measure = data[MEASURE_W-1:0];
            default: ;
        endcase
    endtask

    // one sample request; valid is only dropped when a pause follows
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        int unsigned gap;
        window_t     res;
        gap = tx_steady ? 0 : pick_pause();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (correlate_sample(smp, res)) begin
            pending_windows.push_back(typed_on ? typed_win : res);
        end
    endtask

    // block is idle once every window is back and the pipeline has drained
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- result side
    // Back-pressure comes in stretches: calm, light or heavy stalling.
    int unsigned rx_hold = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_stall_pct = 0;
    window_t     got;
    window_t     want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.power    = m_power;
            got.real_sum = m_real_sum;
            got.imag_sum = m_imag_sum;
            if (pending_windows.size() == 0) begin
                $display("%0t: result with nothing expected: power %0d real %0d imag %0d",
                         $time, got.power, got.real_sum, got.imag_sum);
                errors++;
            end else begin
                want = pending_windows.pop_front();
                if (got.power !== want.power) begin
                    $display("%0t: power expected %0d, got %0d", $time, want.power, got.power);
                    errors++;
                end
                if (got.real_sum !== want.real_sum) begin
                    $display("%0t: real_sum expected %0d, got %0d",
                             $time, want.real_sum, got.real_sum);
                    errors++;
                end
                if (got.imag_sum !== want.imag_sum) begin
                    $display("%0t: imag_sum expected %0d, got %0d",
                             $time, want.imag_sum, got.imag_sum);
                    errors++;
                end
            end
        end
        if (rx_mode_left == 0) begin
            rx_mode_left = $urandom_range(50, 400);
            case ($urandom_range(0, 2))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 15;
                default: rx_stall_pct = 50;
            endcase
        end
        rx_mode_left--;
        if (rx_hold != 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            rx_hold = pick_pause();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus
    plan_row_t plan [12];

    initial begin
        int unsigned     i;
        int unsigned     n;
        int unsigned     span;
        longint unsigned start_items;
        longint unsigned start_windows;
        logic [31:0]     data;

        build_quarter_sine();
        cur_step    = PHASE_STEP_RST;
        cur_discard = DISCARD_COUNT_RST;
        cur_measure = MEASURE_COUNT_RST;
        in_window   = 1'b0;
        win_count   = '0;
        win_phase   = '0;
        acc_re      = 0;
        acc_im      = 0;

        // Directed rows. Single-sample windows at phase zero have cos = full scale and
        // sin = 0, so their sums are just sample * 511 and are typed in directly.
        // no discard; default step and default 5000-sample window, left open
        plan[0]  = mk_row(WR_DISC, 0, 0, 0, 5, FILL_RANDOM, 0, 0, '0);
        // window length lowered under the count mid-window: closes on the next sample
        plan[1]  = mk_row(WR_MEAS, 0, 0, 3, 1, FILL_RANDOM, 0, 0, '0);
        plan[2]  = mk_row(WR_STEP | WR_MEAS, 0, 0, 1, 2, FILL_CONST, 8'sh7F, 1,
                          '{63'd1052905152, 33'sd64897, 33'sd0});
        // zero-length window behaves as one sample; dead index written alongside
        plan[3]  = mk_row(WR_MEAS | WR_SPARE, 0, 0, 0, 2, FILL_CONST, 8'sh80, 1,
                          '{63'd1069551616, -33'sd65408, 33'sd0});
        plan[4]  = mk_row('0, 0, 0, 0, 1, FILL_CONST, 8'sh00, 1, '0);
        plan[5]  = mk_row(WR_STEP | WR_MEAS, 32'hFFFF_FFFF, 0, 4, 4, FILL_SWING, 0, 0, '0);
        plan[6]  = mk_row(WR_STEP, 32'h4000_0000, 0, 0, 4, FILL_CONST, 8'sh80, 0, '0);
        plan[7]  = mk_row(WR_DISC | WR_MEAS, 0, 3, 2, 2, FILL_RANDOM, 0, 0, '0);
        // discard lowered under the running count: next sample is measured
        plan[8]  = mk_row(WR_DISC, 0, 1, 0, 2, FILL_RANDOM, 0, 0, '0);
        plan[9]  = mk_row(WR_DISC, 0, 32'h00FF_FFFF, 0, 3, FILL_RANDOM, 0, 0, '0);
        plan[10] = mk_row(WR_DISC | WR_MEAS, 0, 2, 32'h0000_FFFF, 2, FILL_RANDOM, 0, 0, '0);
        // step and length changed mid-window, window closes on the next sample
        plan[11] = mk_row(WR_STEP | WR_MEAS, 32'h1234_5679, 0, 1, 1, FILL_RANDOM, 0, 0, '0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        foreach (plan[r]) begin
            if ((plan[r].wr & WR_STEP) != 0) begin
                program_reg(CFG_PHASE_STEP, plan[r].step);
            end
            if ((plan[r].wr & WR_DISC) != 0) begin
                program_reg(CFG_DISCARD_COUNT, plan[r].discard);
            end
            if ((plan[r].wr & WR_MEAS) != 0) begin
                program_reg(CFG_MEASURE_COUNT, plan[r].measure);
            end
            if ((plan[r].wr & WR_SPARE) != 0) begin
                program_reg(CFG_SPARE, 32'hFFFF_FFFF);
            end
            typed_on  = plan[r].typed;
            typed_win = plan[r].want;
            for (i = 0; i < plan[r].count; i++) begin
                case (plan[r].fill)
                    FILL_CONST: send_sample(plan[r].level);
                    FILL_SWING: send_sample((i % 2 == 0) ? 8'sh7F : 8'sh80);
                    default:    send_sample(rand_sample());
                endcase
            end
            drain_and_settle();
        end
        typed_on = 1'b0;

        // Random phases: mostly sample runs that complete one or more windows with
        // fresh settings, some cut short so the next writes land mid-discard or
        // mid-window. Upper bits of the narrow registers carry junk.
        start_items   = items_total;
        start_windows = windows_total;
        while (items_total - start_items < RANDOM_SAMPLES ||
               windows_total - start_windows < MIN_RANDOM_WINDOWS) begin
            if ($urandom_range(0, 1) != 0) begin
                case ($urandom_range(0, 5))
                    0:       data = '0;
                    1:       data = 32'hFFFF_FFFF;
                    2:       data = 32'($urandom_range(1, 64)) << (32 - TAB_BITS);
                    default: data = $urandom;
                endcase
                program_reg(CFG_PHASE_STEP, data);
            end
            if ($urandom_range(0, 1) != 0) begin
                n = $urandom_range(0, 19);
                if (n < 12) begin
                    data = $urandom_range(0, 4);
                end else if (n < 18) begin
                    data = $urandom_range(5, 30);
                end else begin
                    data = {8'($urandom), 24'($urandom_range(0, 8))};
                end
                program_reg(CFG_DISCARD_COUNT, data);
            end
            if ($urandom_range(0, 1) != 0) begin
                n = $urandom_range(0, 19);
                if (n < 10) begin
                    data = $urandom_range(1, 8);
                end else if (n < 15) begin
                    data = $urandom_range(9, 48);
                end else if (n < 17) begin
                    data = '0;
                end else begin
                    data = {16'($urandom), 16'($urandom_range(1, 12))};
                end
                program_reg(CFG_MEASURE_COUNT, data);
            end
            if ($urandom_range(0, 9) == 0) begin
                program_reg(CFG_SPARE, $urandom);
            end
            span = int'(cur_discard) + ((cur_measure == 0) ? 1 : int'(cur_measure));
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 10);
            end else begin
                n = span * $urandom_range(1, 3) + $urandom_range(0, 2);
            end
            if (n > 400) begin
                n = 400;
            end
            tx_steady = ($urandom_range(0, 3) == 0);
            for (i = 0; i < n; i++) begin
                send_sample(rand_sample());
            end
            drain_and_settle();
        end

        // One long window at zero step and negative full scale: the real sum only
        // ever moves down. A one-sample window first closes any window left open
        // by the random part.
        tx_steady = 1'b0;
        program_reg(CFG_DISCARD_COUNT, '0);
        program_reg(CFG_MEASURE_COUNT, 32'd1);
        send_sample(rand_sample());
        drain_and_settle();
        program_reg(CFG_PHASE_STEP, '0);
        program_reg(CFG_MEASURE_COUNT, 32'(LONG_WINDOW));
        for (i = 0; i < LONG_WINDOW; i++) begin
            send_sample(8'sh80);
        end
        drain_and_settle();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
